// ----- hw/rtl/svhd_pkg.sv -----
// ----------------------------------------------------------------------------
// svhd_pkg: shared types and constants for the VIS header detector
// Band limits in 1/16 Hz, alignment record layout and result status codes.
// ----------------------------------------------------------------------------
package svhd_pkg;

  // Tone history: one 10 ms frame per entry, oldest at tap 0
  localparam int RING_DEPTH = 45;
  localparam int TONE_W     = 16;
  localparam int DIFF_W     = TONE_W + 1;
  localparam int SHIFT_W    = 12;
  localparam int CODE_W     = 7;
  localparam int NUM_BITS   = 8;
  localparam int NUM_OFFS   = 3;
  localparam int NUM_ALIGN  = NUM_OFFS * NUM_OFFS;

  // Band edges as offsets from the reference tone, 1/16 Hz
  localparam logic signed [DIFF_W-1:0] TOL_LEADER = 17'sd400;    // 25 Hz
  localparam logic signed [DIFF_W-1:0] START_HI   = 17'sd11600;  // 725 Hz
  localparam logic signed [DIFF_W-1:0] START_LO   = 17'sd10800;  // 675 Hz
  localparam logic signed [DIFF_W-1:0] ZERO_HI    = 17'sd10000;  // 625 Hz
  localparam logic signed [DIFF_W-1:0] ZERO_LO    = 17'sd9200;   // 575 Hz
  localparam logic signed [DIFF_W-1:0] ONE_HI     = 17'sd13200;  // 825 Hz
  localparam logic signed [DIFF_W-1:0] ONE_LO     = 17'sd12400;  // 775 Hz
  localparam logic signed [DIFF_W-1:0] LEADER_F   = 17'sd30400;  // 1900 Hz
  localparam logic signed [SHIFT_W-1:0] SHIFT_MAX = 12'sd2047;

  // Configuration register indexes (byte address = 8 * index)
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_VALID_LOW  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_VALID_HIGH = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_INV_PARITY = 2'd2;
  localparam logic [CODE_W-1:0]    INV_PARITY_RST = 7'd6;

  typedef enum logic [1:0] {
    ST_NONE    = 2'd0,
    ST_FOUND   = 2'd1,
    ST_PARITY  = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_t;

  // One alignment after classification: all bits read, and their values
  typedef struct packed {
    logic                read_ok;
    logic [NUM_BITS-1:0] bits;
  } align_t;

  // Word passed from front to back
  typedef struct packed {
    align_t [NUM_ALIGN-1:0]                align;
    logic   [NUM_OFFS-1:0][SHIFT_W-1:0]    shift;
  } entry_t;

  // True when lo < (x - ref) < hi
  function automatic logic in_band(input logic [TONE_W-1:0] x,
                                   input logic [TONE_W-1:0] ref_f,
                                   input logic signed [DIFF_W-1:0] lo,
                                   input logic signed [DIFF_W-1:0] hi);
    logic signed [DIFF_W-1:0] d;
    d = signed'({1'b0, x}) - signed'({1'b0, ref_f});
    return (d > lo) && (d < hi);
  endfunction

endpackage

// ----- hw/rtl/svhd_front.sv -----
// ----------------------------------------------------------------------------
// svhd_front: tone history and band classification
// Shifts each frame into a 45-tap line, then classifies all nine alignments
// and hands one word per frame to the queue.
// ----------------------------------------------------------------------------
module svhd_front import svhd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [TONE_W-1:0] tone_freq,
  input  logic              tone_valid,
  output logic              push_valid,
  input  logic              push_ready,
  output entry_t            push_data
);

  logic [TONE_W-1:0] taps [RING_DEPTH];
  logic              pend;
  logic              pend_next;
  logic              accept;

  logic [NUM_ALIGN-1:0] read_ok;
  logic [NUM_BITS-1:0]  bits_a  [NUM_ALIGN];
  logic [SHIFT_W-1:0]   shift_j [NUM_OFFS];

  // Take a frame once the previous one has been handed on
  assign in_ready   = !pend || push_ready;
  assign accept     = in_valid && in_ready;
  assign push_valid = pend;

  always_comb begin
    pend_next = pend;
    if (accept) begin
      pend_next = 1'b1;
    end else if (push_ready) begin
      pend_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= pend_next;
    end
  end

  // Advance the tone line; an unusable frame repeats the newest tone
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n < RING_DEPTH; n++) begin
        taps[n] <= '0;
      end
    end else if (accept) begin
      for (int n = 0; n < RING_DEPTH - 1; n++) begin
        taps[n] <= taps[n+1];
      end
      taps[RING_DEPTH-1] <= tone_valid ? tone_freq : taps[RING_DEPTH-1];
    end
  end

  // Leader shift per reference tap, truncated toward zero, saturated high
  for (genvar gj = 0; gj < NUM_OFFS; gj++) begin : g_shift
    logic signed [DIFF_W-1:0] diff;
    logic signed [DIFF_W-1:0] adj;
    logic signed [DIFF_W-1:0] quo;
    assign diff = signed'({1'b0, taps[gj]}) - LEADER_F;
    assign adj  = diff[DIFF_W-1] ? (diff + 17'sd15) : diff;
    assign quo  = adj >>> 4;
    assign shift_j[gj] = (quo > DIFF_W'(SHIFT_MAX)) ? SHIFT_MAX : quo[SHIFT_W-1:0];
  end

  // Classify each alignment: offset gi into the frame, reference tap gj
  for (genvar gi = 0; gi < NUM_OFFS; gi++) begin : g_off
    for (genvar gj = 0; gj < NUM_OFFS; gj++) begin : g_ref
      logic [3:0]          lead_ok;
      logic                frame_ok;
      logic [NUM_BITS-1:0] bit_ok;
      logic [NUM_BITS-1:0] bit_val;

      for (genvar gk = 1; gk <= 4; gk++) begin : g_lead
        assign lead_ok[gk-1] = in_band(taps[3*gk+gi], taps[gj], -TOL_LEADER, TOL_LEADER);
      end

      assign frame_ok = (&lead_ok)
                     && in_band(taps[15+gi], taps[gj], -START_HI, -START_LO)
                     && in_band(taps[42+gi], taps[gj], -START_HI, -START_LO);

      for (genvar gb = 0; gb < NUM_BITS; gb++) begin : g_bit
        logic is_zero;
        logic is_one;
        assign is_zero     = in_band(taps[18+gi+3*gb], taps[gj], -ZERO_HI, -ZERO_LO);
        assign is_one      = in_band(taps[18+gi+3*gb], taps[gj], -ONE_HI, -ONE_LO);
        assign bit_ok[gb]  = is_zero || is_one;
        assign bit_val[gb] = is_one;
      end

      assign read_ok[gi*NUM_OFFS+gj] = frame_ok && (&bit_ok);
      assign bits_a[gi*NUM_OFFS+gj]  = bit_val;
    end
  end

  // Pack the queue word
  always_comb begin
    for (int a = 0; a < NUM_ALIGN; a++) begin
      push_data.align[a].read_ok = read_ok[a];
      push_data.align[a].bits    = bits_a[a];
    end
    for (int j = 0; j < NUM_OFFS; j++) begin
      push_data.shift[j] = shift_j[j];
    end
  end

endmodule

// ----- hw/rtl/svhd_queue.sv -----
// ----------------------------------------------------------------------------
// svhd_queue: two-entry queue between classification and decision
// Lets the front and the back stall independently.
// ----------------------------------------------------------------------------
module svhd_queue import svhd_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push_valid,
  output logic   push_ready,
  input  entry_t push_data,
  output logic   pop_valid,
  input  logic   pop_ready,
  output entry_t pop_data
);

  entry_t     slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- hw/rtl/svhd_back.sv -----
// ----------------------------------------------------------------------------
// svhd_back: parity, code mask and alignment priority
// Picks the winning alignment of one word and holds the result for output.
// ----------------------------------------------------------------------------
module svhd_back import svhd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               entry_valid,
  output logic               entry_ready,
  input  entry_t             entry,
  input  logic [63:0]        valid_codes_low,
  input  logic [63:0]        valid_codes_high,
  input  logic [CODE_W-1:0]  inverted_parity_code,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [CODE_W-1:0]  vis_code,
  output logic [SHIFT_W-1:0] shift_hz
);

  logic [127:0]       code_mask;
  status_t            st_a [NUM_ALIGN];
  status_t            res_st;
  logic [CODE_W-1:0]  res_code;
  logic [SHIFT_W-1:0] res_shift;
  logic               take;

  assign code_mask   = {valid_codes_high, valid_codes_low};
  assign entry_ready = !out_valid || out_ready;
  assign take        = entry_valid && entry_ready;

  // Check parity and the mask for every alignment
  always_comb begin
    for (int a = 0; a < NUM_ALIGN; a++) begin
      logic [CODE_W-1:0] code;
      logic              par;
      code = entry.align[a].bits[CODE_W-1:0];
      par  = (^code) ^ (code == inverted_parity_code);
      if (par != entry.align[a].bits[NUM_BITS-1]) begin
        st_a[a] = ST_PARITY;
      end else if (!code_mask[code]) begin
        st_a[a] = ST_UNKNOWN;
      end else begin
        st_a[a] = ST_FOUND;
      end
    end
  end

  // Select: first found wins, else first alignment that read all bits
  always_comb begin
    logic found;
    logic have;
    found     = 1'b0;
    have      = 1'b0;
    res_st    = ST_NONE;
    res_code  = '0;
    res_shift = '0;
    for (int i = 0; i < NUM_OFFS; i++) begin
      for (int j = 0; j < NUM_OFFS; j++) begin
        if (entry.align[i*NUM_OFFS+j].read_ok && !found) begin
          if (st_a[i*NUM_OFFS+j] == ST_FOUND || !have) begin
            res_st    = st_a[i*NUM_OFFS+j];
            res_code  = entry.align[i*NUM_OFFS+j].bits[CODE_W-1:0];
            res_shift = entry.shift[j];
          end
          have = 1'b1;
          if (st_a[i*NUM_OFFS+j] == ST_FOUND) begin
            found = 1'b1;
          end
        end
      end
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (entry_ready) begin
      out_valid <= entry_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      status   <= res_st;
      vis_code <= res_code;
      shift_hz <= res_shift;
    end
  end

endmodule

// ----- hw/rtl/sstv_vis_header_detector_top.sv -----
// Path: an accepted frame passes the tone line, the queue and the output register.
// Throughput: one frame per cycle unless stalled; combinational logic classifies all nine
// alignments in the front stage; a two-entry queue and an output register absorb stalls.
// Reset: synchronous, clears the 45-tap tone history to zero, the mask registers to zero,
// the inverted-parity code to 6 and all valid state; no clearing pass is needed.
// ----------------------------------------------------------------------------
// sstv_vis_header_detector_top: SSTV VIS header detector
// Frame tones in, one status / code / shift result out per frame; APB registers.
// ----------------------------------------------------------------------------
module sstv_vis_header_detector_top import svhd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // frame input
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [TONE_W-1:0]  tone_freq,
  input  logic               tone_valid,
  // result output
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [CODE_W-1:0]  vis_code,
  output logic [SHIFT_W-1:0] shift_hz,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  logic [63:0]       valid_codes_low;
  logic [63:0]       valid_codes_high;
  logic [CODE_W-1:0] inverted_parity_code;
  logic [REG_IDX_W-1:0] reg_idx;
  logic              wr_en;

  logic   push_valid;
  logic   push_ready;
  entry_t push_data;
  logic   pop_valid;
  logic   pop_ready;
  entry_t pop_data;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign wr_en   = psel && penable && pwrite && pready;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_codes_low      <= '0;
      valid_codes_high     <= '0;
      inverted_parity_code <= INV_PARITY_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_VALID_LOW:  valid_codes_low      <= pwdata;
        REG_VALID_HIGH: valid_codes_high     <= pwdata;
        REG_INV_PARITY: inverted_parity_code <= pwdata[CODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    unique case (reg_idx)
      REG_VALID_LOW:  prdata = valid_codes_low;
      REG_VALID_HIGH: prdata = valid_codes_high;
      REG_INV_PARITY: prdata = {{(64-CODE_W){1'b0}}, inverted_parity_code};
      default:        prdata = '0;
    endcase
  end

  svhd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .tone_freq  (tone_freq),
    .tone_valid (tone_valid),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  svhd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  svhd_back u_back (
    .clk                  (clk),
    .rst                  (rst),
    .entry_valid          (pop_valid),
    .entry_ready          (pop_ready),
    .entry                (pop_data),
    .valid_codes_low      (valid_codes_low),
    .valid_codes_high     (valid_codes_high),
    .inverted_parity_code (inverted_parity_code),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .status               (status),
    .vis_code             (vis_code),
    .shift_hz             (shift_hz)
  );

endmodule
